>>> src/efds_pkg.sv
// Shared constants, register codes and types of the earliest-finish device select block.
package efds_pkg;

    // Run length before the device counter wraps
    localparam int MAX_DEVICES = 256;
    localparam int CNT_W       = $clog2(MAX_DEVICES);
    localparam int IDX_W       = 8;

    // Field widths
    localparam int CC_W       = 16;
    localparam int WORD_W     = 32;
    localparam int BW_W       = 16;
    localparam int QUEUED_W   = 48;
    localparam int FINISH_W   = 64;
    localparam int PROD_W     = WORD_W + CC_W;
    localparam int FRAC_W     = 8;
    localparam int DIVIDEND_W = PROD_W + FRAC_W;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

    // Stream word widths
    localparam int S_TDATA_W = BW_W + QUEUED_W;
    localparam int S_TUSER_W = 2;
    localparam int M_DATA_BITS = FINISH_W + 2 * IDX_W + 1;
    localparam int M_TDATA_W = ((M_DATA_BITS + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_DATA_BITS;

    // Register port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_NUM_CHUNKS  = 2'd0,
        REG_CHUNK_BYTES = 2'd1,
        REG_COMPUTE_NS  = 2'd2,
        REG_MERGE_NS    = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [CC_W-1:0]   num_chunks;
        logic [WORD_W-1:0] chunk_bytes;
        logic [WORD_W-1:0] compute_ns_per_chunk;
        logic [WORD_W-1:0] merge_ns_per_chunk;
    } cfg_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [BW_W-1:0]       divisor;
    } div_req_t;

endpackage

>>> src/efds_cfg_regs.sv
// APB register file holding the task description.
module efds_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [efds_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [efds_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [efds_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output efds_pkg::cfg_t                     cfg
);
    import efds_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // Register writes, upper data bits dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            case (idx)
                REG_NUM_CHUNKS:  cfg_reg.num_chunks           <= pwdata[CC_W-1:0];
                REG_CHUNK_BYTES: cfg_reg.chunk_bytes          <= pwdata[WORD_W-1:0];
                REG_COMPUTE_NS:  cfg_reg.compute_ns_per_chunk <= pwdata[WORD_W-1:0];
                REG_MERGE_NS:    cfg_reg.merge_ns_per_chunk   <= pwdata[WORD_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (idx)
            REG_NUM_CHUNKS:  prdata = APB_DATA_W'(cfg_reg.num_chunks);
            REG_CHUNK_BYTES: prdata = APB_DATA_W'(cfg_reg.chunk_bytes);
            REG_COMPUTE_NS:  prdata = APB_DATA_W'(cfg_reg.compute_ns_per_chunk);
            REG_MERGE_NS:    prdata = APB_DATA_W'(cfg_reg.merge_ns_per_chunk);
            default:         prdata = '0;
        endcase
    end

endmodule

>>> src/efds_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module efds_divider (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  efds_pkg::div_req_t                  req,
    output logic                                busy,
    output logic [efds_pkg::DIVIDEND_W-1:0]     quotient
);
    import efds_pkg::*;

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [BW_W-1:0]       rem_reg;
    logic [BW_W-1:0]       dvs_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic                  busy_reg;

    logic [BW_W:0] trial;
    logic [BW_W:0] diff;
    logic          ge;

    // Shift next dividend bit into the partial remainder and try a subtract
    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};

    assign busy     = busy_reg;
    assign quotient = quo_reg;

    // Step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(DIVIDEND_W - 1);
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Datapath: quotient bits enter at the bottom as dividend bits leave the top
    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], ge};
            rem_reg <= ge ? diff[BW_W-1:0] : trial[BW_W-1:0];
        end
    end

endmodule

>>> src/earliest_finish_device_select_unit.sv
// Top level: sequencer, shared multiplier and adder, running minimum, output register.
//
//  Port group   Dir  Contents
//  s_*          in   one device word: queue load, bandwidth, flags, tlast ends the run
//  m_*          out  one result word per device: finish estimate, indices, found flag
//  p*           in   APB register port, four task registers at byte address 4*i
//
// An item passes from acceptance to its result in the output register through the sequencer
// states; the 56-step bit-serial transfer divide is the long step. A CPU device or one
// with zero bandwidth skips the divide.
// s_tready is high only while the sequencer is idle; a waiting result does not
// block acceptance, but a finished item holds until the output register is free.
// Reset clears the registers, the run state and the output valid.
module earliest_finish_device_select_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Device words
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [15:0] bandwidth_q8, [63:16] queued_ns
    input  logic [efds_pkg::S_TDATA_W-1:0]      s_tdata,
    // [0] available, [1] is_cpu
    input  logic [efds_pkg::S_TUSER_W-1:0]      s_tuser,
    input  logic                                s_tlast,
    // Result words
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [63:0] finish_ns, [71:64] device_index, [79:72] best_index, [80] best_found
    output logic [efds_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast,
    // Register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [efds_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [efds_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [efds_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import efds_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_BYTES,
        ST_DIV_START,
        ST_ADD_COMP,
        ST_ADD_MERGE,
        ST_DIV_WAIT,
        ST_OUT
    } state_t;

    state_t state_reg;

    cfg_t     cfg;
    div_req_t div_req;
    logic     div_busy;
    logic [DIVIDEND_W-1:0] div_quo;

    // Latched device word
    logic                avail_reg;
    logic                xfer_en_reg;
    logic                last_reg;
    logic [BW_W-1:0]     bw_reg;
    logic [QUEUED_W-1:0] queued_reg;

    // Arithmetic
    logic [WORD_W-1:0]   mul_a;
    logic [PROD_W-1:0]   prod_reg;
    logic [FINISH_W-1:0] sum_reg;
    logic [FINISH_W-1:0] addend;
    logic [FINISH_W-1:0] sum_add;

    // Run state
    logic [FINISH_W-1:0] best_time_reg;
    logic [CNT_W-1:0]    best_pos_reg;
    logic                any_found_reg;
    logic [CNT_W-1:0]    cnt_reg;

    // Output register
    logic                 m_valid_reg;
    logic                 m_last_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    logic [FINISH_W-1:0] finish;
    logic                better;
    logic [CNT_W-1:0]    pos_new;
    logic                found_new;
    logic                out_free;

    efds_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    efds_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign out_free = !m_valid_reg || m_tready;

    // Divide request: total bytes * 256 / bandwidth
    assign div_req.start    = (state_reg == ST_DIV_START) && xfer_en_reg;
    assign div_req.dividend = {prod_reg, {FRAC_W{1'b0}}};
    assign div_req.divisor  = bw_reg;

    // Shared multiplier: bytes, then compute, then merge time, all times the chunk count
    always_comb begin
        case (state_reg)
            ST_MUL_BYTES: mul_a = cfg.chunk_bytes;
            ST_DIV_START: mul_a = cfg.compute_ns_per_chunk;
            default:      mul_a = cfg.merge_ns_per_chunk;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * cfg.num_chunks;
    end

    // Shared adder; the terms stay below 2^57, so the sum never saturates
    always_comb begin
        if (state_reg == ST_DIV_WAIT) begin
            addend = xfer_en_reg ? FINISH_W'(div_quo) : '0;
        end else begin
            addend = FINISH_W'(prod_reg);
        end
    end
    assign sum_add = sum_reg + addend;

    // Running minimum, strict less so the earliest device wins a tie
    assign finish    = avail_reg ? sum_reg : '1;
    assign better    = avail_reg && (finish < best_time_reg);
    assign pos_new   = better ? cnt_reg : best_pos_reg;
    assign found_new = any_found_reg || better;

    // Sequencer, run state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            best_time_reg <= '1;
            best_pos_reg  <= '0;
            any_found_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            // Result taken; in ST_OUT the load below decides the valid
            if (m_valid_reg && m_tready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        avail_reg   <= s_tuser[0];
                        xfer_en_reg <= !s_tuser[1] && (s_tdata[BW_W-1:0] != '0);
                        bw_reg      <= s_tdata[BW_W-1:0];
                        queued_reg  <= s_tdata[S_TDATA_W-1:BW_W];
                        last_reg    <= s_tlast;
                        state_reg   <= ST_MUL_BYTES;
                    end
                end
                ST_MUL_BYTES: begin
                    sum_reg   <= FINISH_W'(queued_reg);
                    state_reg <= ST_DIV_START;
                end
                ST_DIV_START: begin
                    state_reg <= ST_ADD_COMP;
                end
                ST_ADD_COMP: begin
                    sum_reg   <= sum_add;
                    state_reg <= ST_ADD_MERGE;
                end
                ST_ADD_MERGE: begin
                    sum_reg   <= sum_add;
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    if (!div_busy) begin
                        sum_reg   <= sum_add;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_last_reg  <= last_reg;
                        m_data_reg  <= {{M_PAD_W{1'b0}},
                                        last_reg && found_new,
                                        last_reg ? IDX_W'(pos_new) : {IDX_W{1'b0}},
                                        IDX_W'(cnt_reg),
                                        finish};
                        if (last_reg) begin
                            best_time_reg <= '1;
                            best_pos_reg  <= '0;
                            any_found_reg <= 1'b0;
                            cnt_reg       <= '0;
                        end else begin
                            if (better) begin
                                best_time_reg <= finish;
                            end
                            best_pos_reg  <= pos_new;
                            any_found_reg <= found_new;
                            cnt_reg <= (cnt_reg == CNT_W'(MAX_DEVICES - 1)) ? '0
                                                                            : cnt_reg + 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

>>> verif/efds_checker.sv
// Checker for the device select unit: predicts each result word and compares it field by field.
`timescale 1ns / 1ps

module efds_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // [15:0] bandwidth_q8, [63:16] queued_ns
    input  logic [efds_pkg::S_TDATA_W-1:0]  s_tdata,
    // [0] available, [1] is_cpu
    input  logic [efds_pkg::S_TUSER_W-1:0]  s_tuser,
    input  logic                            s_tlast,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // [63:0] finish_ns, [71:64] device_index, [79:72] best_index, [80] best_found
    input  logic [efds_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            m_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [efds_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [efds_pkg::APB_DATA_W-1:0] pwdata,
    output int                              fail_count,
    output int                              results_checked,
    output int                              pending
);
    import efds_pkg::*;

    typedef struct {
        logic [FINISH_W-1:0] finish_ns;
        logic [IDX_W-1:0]    device_index;
        logic [IDX_W-1:0]    best_index;
        logic                best_found;
        logic                last_result;
    } finish_word_t;

    // Results still owed by the block, oldest first
    finish_word_t finish_q[$];
    finish_word_t want;
    finish_word_t got_next;

    // Task settings as written over the register port
    cfg_t task_cfg;

    // Running minimum of the current selection run
    logic [FINISH_W-1:0] min_finish;
    logic [IDX_W-1:0]    best_position;
    logic                any_found;
    int                  device_count;
    logic [FINISH_W-1:0] estimate;

    function automatic logic [FINISH_W-1:0] sat_sum(input logic [FINISH_W-1:0] a,
                                                     input logic [FINISH_W-1:0] b);
        logic [FINISH_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[FINISH_W] ? '1 : s[FINISH_W-1:0];
    endfunction

    // queue load + transfer + compute + merge, all in ns
    function automatic logic [FINISH_W-1:0] finish_time(input cfg_t c, input logic avail,
                                                         input logic cpu,
                                                         input logic [BW_W-1:0] bw,
                                                         input logic [QUEUED_W-1:0] queued);
        logic [FINISH_W-1:0] chunks;
        logic [FINISH_W-1:0] per_chunk_bytes;
        logic [FINISH_W-1:0] compute;
        logic [FINISH_W-1:0] merge;
        logic [FINISH_W-1:0] rate;
        logic [FINISH_W-1:0] load;
        logic [FINISH_W-1:0] transfer;
        logic [FINISH_W-1:0] total;
        chunks          = FINISH_W'(c.num_chunks);
        per_chunk_bytes = FINISH_W'(c.chunk_bytes);
        compute         = FINISH_W'(c.compute_ns_per_chunk);
        merge           = FINISH_W'(c.merge_ns_per_chunk);
        rate            = FINISH_W'(bw);
        load            = FINISH_W'(queued);
        if (!avail) begin
            return '1;
        end
        if (chunks == '0) begin
            return load;
        end
        transfer = '0;
        if (bw != '0 && !cpu) begin
            transfer = ((per_chunk_bytes * chunks) << FRAC_W) / rate;
        end
        total = sat_sum(load, transfer);
        total = sat_sum(total, compute * chunks);
        total = sat_sum(total, merge * chunks);
        return total;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [FINISH_W-1:0] got,
                               input logic [FINISH_W-1:0] exp);
        if (got !== exp) begin
            report_mismatch($sformatf("device %0d %s got %h expected %h",
                                      want.device_index, name, got, exp));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            task_cfg        = '0;
            min_finish      = '1;
            best_position   = '0;
            any_found       = 1'b0;
            device_count    = 0;
            fail_count      = 0;
            results_checked = 0;
            finish_q.delete();
            pending        <= 0;
        end else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_NUM_CHUNKS:  task_cfg.num_chunks           = pwdata[CC_W-1:0];
                    REG_CHUNK_BYTES: task_cfg.chunk_bytes          = pwdata[WORD_W-1:0];
                    REG_COMPUTE_NS:  task_cfg.compute_ns_per_chunk = pwdata[WORD_W-1:0];
                    REG_MERGE_NS:    task_cfg.merge_ns_per_chunk   = pwdata[WORD_W-1:0];
                    default: ;
                endcase
            end

            // device word in: estimate and update the running minimum
            if (s_tvalid && s_tready) begin
                estimate = finish_time(task_cfg, s_tuser[0], s_tuser[1],
                                       s_tdata[BW_W-1:0], s_tdata[BW_W +: QUEUED_W]);
                if (s_tuser[0] && estimate < min_finish) begin
                    min_finish    = estimate;
                    best_position = device_count[IDX_W-1:0];
                    any_found     = 1'b1;
                end
                got_next.finish_ns    = estimate;
                got_next.device_index = device_count[IDX_W-1:0];
                got_next.best_index   = s_tlast ? best_position : '0;
                got_next.best_found   = s_tlast && any_found;
                got_next.last_result  = s_tlast;
                finish_q.push_back(got_next);
                if (s_tlast) begin
                    min_finish    = '1;
                    best_position = '0;
                    any_found     = 1'b0;
                    device_count  = 0;
                end else begin
                    device_count = (device_count + 1 >= MAX_DEVICES) ? 0 : device_count + 1;
                end
            end

            // result word out
            if (m_tvalid && m_tready) begin
                if (finish_q.size() == 0) begin
                    report_mismatch($sformatf("result word %h with nothing pending", m_tdata));
                end else begin
                    want = finish_q.pop_front();
                    results_checked++;
                    check_field("finish_ns", m_tdata[FINISH_W-1:0], want.finish_ns);
                    check_field("device_index", FINISH_W'(m_tdata[FINISH_W +: IDX_W]),
                                FINISH_W'(want.device_index));
                    check_field("best_index", FINISH_W'(m_tdata[FINISH_W+IDX_W +: IDX_W]),
                                FINISH_W'(want.best_index));
                    check_field("best_found", FINISH_W'(m_tdata[FINISH_W+2*IDX_W]),
                                FINISH_W'(want.best_found));
                    check_field("pad bits", FINISH_W'(m_tdata[M_TDATA_W-1:M_DATA_BITS]), '0);
                    check_field("tlast", FINISH_W'(m_tlast), FINISH_W'(want.last_result));
                end
            end

            pending <= finish_q.size();
        end
    end

endmodule

>>> verif/earliest_finish_device_select_unit_test.sv
// Testbench top for the device select unit: stimulus, idling, register setup and verdict.
`timescale 1ns / 1ps

module earliest_finish_device_select_unit_test;
    import efds_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 70;
    localparam int RUN_QUOTA    = 25;
    localparam int LONG_RUN     = 260;

    typedef enum logic [1:0] {RX_OPEN, RX_JITTER, RX_SLOW} rx_mode_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // [15:0] bandwidth_q8, [63:16] queued_ns
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    // [0] available, [1] is_cpu
    logic [S_TUSER_W-1:0]  s_tuser  = '0;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [63:0] finish_ns, [71:64] device_index, [79:72] best_index, [80] best_found
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int results_checked;
    int pending;

    int words_sent      = 0;
    int runs_sent       = 0;
    int reg_writes      = 0;
    int burst_left      = 0;
    int holds_requested = 0;
    int hold_seen       = 0;
    int hold_left       = 0;
    int stretch_left    = 0;
    int idle_cycles     = 0;
    rx_mode_t rx_mode   = RX_OPEN;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    earliest_finish_device_select_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    efds_checker finish_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .fail_count      (fail_count),
        .results_checked (results_checked),
        .pending         (pending)
    );

    // Setup then access phase, then idle with psel low so writes never share a step
    task automatic reg_write(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        reg_writes++;
    endtask

    // Offer one device word; bursts of random length with random gaps between
    task automatic send_device(input logic avail, input logic cpu, input logic [BW_W-1:0] bw,
                               input logic [QUEUED_W-1:0] queued, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 120)
                                                     : $urandom_range(0, 6);
            burst_left = $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {queued, bw};
        s_tuser  <= {cpu, avail};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        if (last) begin
            runs_sent++;
        end
    endtask

    // Mostly available devices with close queue loads, so the minimum moves around
    task automatic random_device(input logic last);
        logic                avail;
        logic                cpu;
        logic [BW_W-1:0]     bw;
        logic [QUEUED_W-1:0] queued;
        avail = ($urandom_range(0, 9) != 0);
        cpu   = ($urandom_range(0, 4) == 0);
        case ($urandom_range(0, 9))
            0:       bw = '0;
            1:       bw = '1;
            2:       bw = 16'd1;
            default: bw = BW_W'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0:       queued = '0;
            1:       queued = '1;
            2, 3:    queued = QUEUED_W'({$urandom, $urandom});
            default: queued = QUEUED_W'($urandom_range(0, 5000));
        endcase
        send_device(avail, cpu, bw, queued, last);
    endtask

    task automatic random_run(input int len);
        for (int i = 0; i < len; i++) begin
            random_device(i == len - 1);
        end
    endtask

    function automatic logic [APB_DATA_W-1:0] pick_setting();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return $urandom_range(1, 16);
            4:       return $urandom_range(0, 4095);
            default: return $urandom;
        endcase
    endfunction

    // Wait until every owed result is out and the block is idle again
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Receiver: long hold-off on request, else stretches of open, jittery or slow acceptance
    always @(posedge aclk) begin
        if (holds_requested != hold_seen) begin
            hold_seen = holds_requested;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (stretch_left == 0) begin
                rx_mode      = rx_mode_t'($urandom_range(0, 2));
                stretch_left = $urandom_range(8, 60);
            end
            stretch_left--;
            case (rx_mode)
                RX_OPEN:   m_tready <= 1'b1;
                RX_JITTER: m_tready <= ($urandom_range(0, 3) != 0);
                default:   m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Watchdog on cycles with no word moved on any port
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int filled;
        int len;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: estimate is the queue load alone
        send_device(1'b1, 1'b0, 16'h0100, '1, 1'b0);
        send_device(1'b0, 1'b1, 16'hFFFF, '0, 1'b0);
        send_device(1'b1, 1'b1, 16'h0000, '0, 1'b1);
        wait_idle();

        // chunk count written as zero through its discarded upper bits
        reg_write(REG_NUM_CHUNKS, 32'h0001_0000);
        reg_write(REG_CHUNK_BYTES, 32'h0000_1000);
        reg_write(REG_COMPUTE_NS, 32'd7);
        reg_write(REG_MERGE_NS, 32'd9);
        send_device(1'b1, 1'b0, 16'h0001, 48'd100, 1'b0);
        send_device(1'b1, 1'b0, 16'h0080, 48'd50, 1'b1);
        wait_idle();

        // every setting at its top value
        reg_write(REG_NUM_CHUNKS, 32'hABCD_FFFF);
        reg_write(REG_CHUNK_BYTES, '1);
        reg_write(REG_COMPUTE_NS, '1);
        reg_write(REG_MERGE_NS, '1);
        send_device(1'b1, 1'b0, 16'h0001, '0, 1'b0);
        send_device(1'b1, 1'b0, 16'hFFFF, '0, 1'b0);
        send_device(1'b1, 1'b0, 16'h0000, '1, 1'b0);
        send_device(1'b1, 1'b1, 16'h0001, '0, 1'b0);
        send_device(1'b0, 1'b0, 16'hFFFF, '0, 1'b0);
        send_device(1'b1, 1'b0, 16'hFFFF, '1, 1'b1);
        // a run where nothing is available
        send_device(1'b0, 1'b0, 16'h0000, '0, 1'b0);
        send_device(1'b0, 1'b1, 16'hFFFF, '1, 1'b1);
        wait_idle();

        // small settings: tie goes to the earlier device, then a single-device run and a two-device run
        reg_write(REG_NUM_CHUNKS, 32'd1);
        reg_write(REG_CHUNK_BYTES, 32'd1);
        reg_write(REG_COMPUTE_NS, 32'd0);
        reg_write(REG_MERGE_NS, 32'd0);
        send_device(1'b1, 1'b0, 16'h0100, 48'd5, 1'b0);
        send_device(1'b1, 1'b0, 16'h0100, 48'd5, 1'b0);
        send_device(1'b1, 1'b0, 16'h0080, 48'd5, 1'b1);
        send_device(1'b1, 1'b1, 16'h0000, 48'd3, 1'b1);
        send_device(1'b1, 1'b0, 16'h0001, 48'h8000_0000_0000, 1'b0);
        send_device(1'b1, 1'b0, 16'h8000, 48'd0, 1'b1);
        wait_idle();

        // random phases, each under fresh settings; one run wraps the device index
        for (int phase = 0; phase < 7; phase++) begin
            reg_write(REG_NUM_CHUNKS, pick_setting());
            reg_write(REG_CHUNK_BYTES, pick_setting());
            reg_write(REG_COMPUTE_NS, pick_setting());
            reg_write(REG_MERGE_NS, pick_setting());
            if (phase == 1 || phase == 3) begin
                holds_requested <= holds_requested + 1;
            end
            if (phase == 3) begin
                random_run(LONG_RUN);
            end else begin
                filled = 0;
                while (filled < RUN_QUOTA) begin
                    len = $urandom_range(1, 10);
                    random_run(len);
                    filled += len;
                end
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Covered %0d device words in %0d selection runs over %0d register writes,",
                 words_sent, runs_sent, reg_writes);
        $display("%0d result words checked, including a run that wrapped the device index.",
                 results_checked);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/efds_pkg.sv
src/efds_cfg_regs.sv
src/efds_divider.sv
src/earliest_finish_device_select_unit.sv
verif/efds_checker.sv
verif/earliest_finish_device_select_unit_test.sv
